### rtl/spdg_pkg.sv
// ----------------------------------------------------------------------------
// spdg_pkg: shared types and constants for the shortest path engine
// Request and response structures, the opcode and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package spdg_pkg;

	// Fixed field widths of the request and response
	localparam int VIDX_W        = 4;
	localparam int COST_W        = 32;
	localparam int VCOUNT_W      = 5;
	localparam int VCOUNT_RESET  = 16;
	localparam int MAX_RESULTS   = 15;
	localparam int CNT_W         = 4;

	typedef enum logic {
		OP_SET_EDGE = 1'b0,
		OP_QUERY    = 1'b1
	} spdg_op_t;

	typedef struct packed {
		spdg_op_t            op;
		logic [VIDX_W-1:0]   src_vertex;
		logic [VIDX_W-1:0]   dst_vertex;
		logic [COST_W-1:0]   edge_weight;
	} spdg_req_t;

	typedef struct packed {
		logic [VIDX_W-1:0]   edge_from;
		logic [VIDX_W-1:0]   edge_to;
		logic [COST_W-1:0]   path_cost;
		logic                found;
		logic                last;
	} spdg_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_RELAX,
		ST_RWAIT,
		ST_SELECT,
		ST_CHECK,
		ST_W_NODE,
		ST_W_EDGE,
		ST_W_ADD,
		ST_E_NODE,
		ST_E_OUT,
		ST_NOT_FOUND
	} spdg_state_t;

endpackage

`default_nettype wire

### rtl/spdg_ram.sv
// ----------------------------------------------------------------------------
// spdg_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module spdg_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/shortest_path_dense_graph.sv
// ----------------------------------------------------------------------------
// shortest_path_dense_graph: Dijkstra engine over a dense edge weight matrix
// Set-edge request: one matrix write, no response.
// Query: a search over k vertices taken (n in use), each with a row sweep, then
//   a walk back along the path to total the cost and a second walk to emit; the
//   matrix read port and the row sweep over n vertices set the search time.
// One request is worked on at a time. After reset the matrix is swept to
//   "no edge", 2**(2*clog2(NUM_VERTICES)) entries (256 by default), no requests.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_path_dense_graph
	import spdg_pkg::*;
#(
	parameter int NUM_VERTICES = 16,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  spdg_req_t           in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spdg_rsp_t           out_data
);

	// Vertex index width, vertex count width and memory geometry.
	localparam int VW  = $clog2(NUM_VERTICES);
	localparam int CW  = $clog2(NUM_VERTICES + 1);
	localparam int EAW = 2 * VW;
	localparam int NDW = VW + WEIGHT_BITS;
	localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
	localparam logic [CW-1:0] N_RESET =
		CW'((VCOUNT_RESET > NUM_VERTICES) ? NUM_VERTICES : VCOUNT_RESET);

	// Saturating add: any sum that reaches all ones is "unreachable".
	function automatic logic [WEIGHT_BITS-1:0] sat_add(
		input logic [WEIGHT_BITS-1:0] a,
		input logic [WEIGHT_BITS-1:0] b
	);
		logic [WEIGHT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s >= {1'b0, WMAX}) ? WMAX : s[WEIGHT_BITS-1:0];
	endfunction

	spdg_state_t state_q, state_d;

	// Configuration and captured query
	logic [CW-1:0]      n_q;
	logic [VIDX_W-1:0]  s_q, t_q;

	// Search state: vertex being expanded, its distance, the row sweep index
	logic [VW-1:0]          u_q, v_q;
	logic [WEIGHT_BITS-1:0] du_q;
	logic [NUM_VERTICES-1:0] unvis_q, known_q, pvalid_q;
	logic [WEIGHT_BITS-1:0] best_val_q;
	logic [VW-1:0]          best_idx_q;
	logic                   have_q;
	logic                   rv_s1;
	logic [VW-1:0]          v_s1;

	// Matrix clearing sweep after reset
	logic [EAW-1:0] clr_q;

	// Backward walk and emission
	logic [VW-1:0]          cur_q, wu_q;
	logic [WEIGHT_BITS-1:0] cost_q;
	logic [CNT_W-1:0]       cnt_q, k_q;

	logic      out_valid_q;
	spdg_rsp_t out_q, out_d;
	logic      out_load;

	// Memory ports
	logic                   e_we, e_re;
	logic [EAW-1:0]         e_waddr, e_raddr;
	logic [WEIGHT_BITS-1:0] e_wdata, e_rdata;
	logic                   n_we, n_re;
	logic [VW-1:0]          n_waddr, n_raddr;
	logic [NDW-1:0]         n_wdata, n_rdata;

	// Edge weight matrix, addressed {from, to}.
	spdg_ram #(
		.WIDTH  (WEIGHT_BITS),
		.ADDR_W (EAW)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Per-vertex record: {predecessor, distance}. Entries are only trusted
	// where known_q (distance) or pvalid_q (predecessor) says so.
	spdg_ram #(
		.WIDTH  (NDW),
		.ADDR_W (VW)
	) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// ------------------------------------------------------------------
	// Derived values
	// ------------------------------------------------------------------
	logic [VW-1:0]           s_idx, t_idx, n_pred;
	logic [WEIGHT_BITS-1:0]  n_dist;
	logic                    s_in_use, t_in_range, v_last;
	logic [NUM_VERTICES-1:0] init_mask, s_onehot;
	logic [WEIGHT_BITS-1:0]  old_d, relax_sum, new_d;
	logic                    upd, better;
	logic [WEIGHT_BITS-1:0]  w_cost;
	logic [CNT_W-1:0]        w_cnt;
	logic                    w_hit_src, w_full, e_last, out_free, in_acc;

	assign s_idx      = VW'(s_q);
	assign t_idx      = VW'(t_q);
	assign n_pred     = n_rdata[NDW-1 -: VW];
	assign n_dist     = n_rdata[WEIGHT_BITS-1:0];
	assign s_in_use   = int'(s_q) < int'(n_q);
	assign t_in_range = int'(t_q) < NUM_VERTICES;
	assign v_last     = (CW'(v_q) == n_q - CW'(1));

	always_comb begin
		for (int i = 0; i < NUM_VERTICES; i++) begin
			init_mask[i] = (i < int'(n_q));
			s_onehot[i]  = (i == int'(s_q));
		end
	end

	// Relaxation stage: the matrix entry u->v and the record of v arrive in the
	// cycle after the row sweep issued them. A vertex never written in this
	// query reads as unreached. The minimum over the still unvisited
	// vertices is tracked on the fly from the updated distances, so the next
	// vertex is known as soon as the row is done; strict compare keeps the
	// lower index on ties.
	assign old_d     = known_q[v_s1] ? n_dist : WMAX;
	assign relax_sum = sat_add(du_q, e_rdata);
	assign upd       = rv_s1 && (e_rdata != WMAX) && (old_d > relax_sum);
	assign new_d     = upd ? relax_sum : old_d;
	assign better    = rv_s1 && unvis_q[v_s1] && (new_d < best_val_q);

	// Backward walk: totals the cost and counts the edges before anything is
	// emitted, since every response carries the whole path cost.
	assign w_cost    = sat_add(cost_q, e_rdata);
	assign w_cnt     = cnt_q + CNT_W'(1);
	assign w_hit_src = (int'(wu_q) == int'(s_q));
	assign w_full    = (w_cnt == CNT_W'(MAX_RESULTS));
	assign e_last    = (k_q + CNT_W'(1) == cnt_q);

	assign out_free  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Controller: next state and memory strobes
	// ------------------------------------------------------------------
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		e_we     = 1'b0;
		e_waddr  = '0;
		e_wdata  = WMAX;
		e_re     = 1'b0;
		e_raddr  = '0;
		n_re     = 1'b0;
		n_raddr  = '0;
		out_load = 1'b0;
		out_d    = '0;
		// Relaxation write-back; the row sweep never reads the entry it is
		// writing in the same cycle, so no forwarding is needed.
		n_we     = upd;
		n_waddr  = v_s1;
		n_wdata  = {u_q, relax_sum};

		unique case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = clr_q;
				e_wdata = WMAX;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.op == OP_QUERY) begin
						state_d = ST_START;
					end else if (int'(in_data.src_vertex) < NUM_VERTICES &&
					             int'(in_data.dst_vertex) < NUM_VERTICES) begin
						e_we    = 1'b1;
						e_waddr = {VW'(in_data.src_vertex), VW'(in_data.dst_vertex)};
						e_wdata = in_data.edge_weight[WEIGHT_BITS-1:0];
					end
				end
			end
			ST_START: begin
				// The source is expanded first with distance zero. A source
				// outside the vertices in use reaches nothing.
				if (s_in_use) begin
					n_we    = 1'b1;
					n_waddr = s_idx;
					n_wdata = '0;
					state_d = ST_RELAX;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_RELAX: begin
				e_re    = 1'b1;
				e_raddr = {u_q, v_q};
				n_re    = 1'b1;
				n_raddr = v_q;
				if (v_last) begin
					state_d = ST_RWAIT;
				end
			end
			ST_RWAIT: begin
				state_d = ST_SELECT;
			end
			ST_SELECT: begin
				// With no unvisited vertex at a known distance, the rest of
				// the search can change nothing.
				state_d = have_q ? ST_RELAX : ST_CHECK;
			end
			ST_CHECK: begin
				if (t_in_range && pvalid_q[t_idx]) begin
					state_d = ST_W_NODE;
				end else begin
					state_d = ST_NOT_FOUND;
				end
			end
			ST_W_NODE: begin
				n_re    = 1'b1;
				n_raddr = cur_q;
				state_d = ST_W_EDGE;
			end
			ST_W_EDGE: begin
				e_re    = 1'b1;
				e_raddr = {n_pred, cur_q};
				state_d = ST_W_ADD;
			end
			ST_W_ADD: begin
				if (w_hit_src) begin
					state_d = ST_E_NODE;
				end else if (!pvalid_q[wu_q] || w_full) begin
					state_d = ST_NOT_FOUND;
				end else begin
					state_d = ST_W_NODE;
				end
			end
			ST_E_NODE: begin
				n_re    = 1'b1;
				n_raddr = cur_q;
				state_d = ST_E_OUT;
			end
			ST_E_OUT: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.edge_from = VIDX_W'(n_pred);
					out_d.edge_to   = VIDX_W'(cur_q);
					out_d.path_cost = COST_W'(cost_q);
					out_d.found     = 1'b1;
					out_d.last      = e_last;
					state_d         = e_last ? ST_IDLE : ST_E_NODE;
				end
			end
			ST_NOT_FOUND: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.edge_from = s_q;
					out_d.edge_to   = t_q;
					out_d.path_cost = COST_W'(WMAX);
					out_d.found     = 1'b0;
					out_d.last      = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			n_q         <= N_RESET;
			clr_q       <= '0;
			unvis_q     <= '0;
			known_q     <= '0;
			pvalid_q    <= '0;
			have_q      <= 1'b0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == ST_RELAX);

			// A count above the vertex capacity saturates to it.
			if (cfg_we) begin
				n_q <= (int'(cfg_wdata) > NUM_VERTICES) ?
				       CW'(NUM_VERTICES) : CW'(cfg_wdata);
			end

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + EAW'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_START) begin
				unvis_q  <= init_mask & ~s_onehot;
				known_q  <= s_onehot;
				pvalid_q <= '0;
				have_q   <= 1'b0;
			end

			if (upd) begin
				known_q[v_s1]  <= 1'b1;
				pvalid_q[v_s1] <= 1'b1;
			end

			if (better) begin
				have_q <= 1'b1;
			end

			if (state_q == ST_SELECT && have_q) begin
				unvis_q[best_idx_q] <= 1'b0;
				have_q              <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		v_s1 <= v_q;

		if (in_acc) begin
			s_q <= in_data.src_vertex;
			t_q <= in_data.dst_vertex;
		end

		if (state_q == ST_START) begin
			u_q        <= s_idx;
			du_q       <= '0;
			v_q        <= '0;
			best_val_q <= WMAX;
		end

		if (state_q == ST_RELAX) begin
			v_q <= v_q + VW'(1);
		end

		if (better) begin
			best_val_q <= new_d;
			best_idx_q <= v_s1;
		end

		if (state_q == ST_SELECT) begin
			u_q        <= best_idx_q;
			du_q       <= best_val_q;
			v_q        <= '0;
			best_val_q <= WMAX;
		end

		if (state_q == ST_CHECK) begin
			cur_q  <= t_idx;
			cost_q <= '0;
			cnt_q  <= '0;
		end

		if (state_q == ST_W_EDGE) begin
			wu_q <= n_pred;
		end

		// After the counting walk, the emission walk restarts at the target.
		if (state_q == ST_W_ADD) begin
			cost_q <= w_cost;
			cnt_q  <= w_cnt;
			cur_q  <= w_hit_src ? t_idx : wu_q;
			k_q    <= '0;
		end

		if (state_q == ST_E_OUT && out_free && !e_last) begin
			cur_q <= n_pred;
			k_q   <= k_q + CNT_W'(1);
		end

		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### rtl/spdg_checker.sv
// ----------------------------------------------------------------------------
// spdg_checker: port-level checks for the shortest path engine
// Watches the request and response channels and checks response ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module spdg_checker
	import spdg_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input spdg_req_t in_data,
	input logic      out_valid,
	input logic      out_ready,
	input spdg_rsp_t out_data
);

	logic              mid_q;
	logic [COST_W-1:0] prev_cost_q;
	logic [VIDX_W-1:0] prev_from_q;

	// Set while a found path is part way through being delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			mid_q <= out_data.found && !out_data.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && out_ready) begin
			prev_cost_q <= out_data.path_cost;
			prev_from_q <= out_data.edge_from;
		end
	end

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == OP_QUERY |=> !in_ready)
		else $error("query accepted but next request not held off");

	a_not_found_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.last && (&out_data.path_cost[7:0]) && !mid_q)
		else $error("not-found response malformed or inside a path");

	a_cost_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |->
			out_data.found && out_data.path_cost == prev_cost_q)
		else $error("path cost changed within one answer");

	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> out_data.edge_to == prev_from_q)
		else $error("path edges do not chain back toward the source");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled response dropped or changed");

endmodule

bind shortest_path_dense_graph spdg_checker u_spdg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for shortest_path_dense_graph
// Edge writes and path queries go in over a valid/ready channel in random
// bursts. Each accepted request runs through a local Dijkstra predictor that
// keeps its own edge matrix. Every path edge that comes out is checked
// against the oldest predicted one while the receiver stalls at random. The
// vertex count is changed only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------

module tb;
	import spdg_pkg::*;

	localparam int NV        = 16;        // vertex slots in the matrix
	localparam int RUN_LIMIT = 1000000;   // cycles before the run is called hung
	localparam int IDLE_GAP  = 16;        // settle time before a register write
	localparam int END_WAIT  = 400;       // drain time at the end of the run
	localparam logic [COST_W-1:0] NO_EDGE = '1;

	// Clock and the signals that drive the block. Every input starts out known.
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [VCOUNT_W-1:0] cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	spdg_req_t           in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	spdg_rsp_t           out_data;

	// Requests still to be sent, and path edges that the block still owes.
	spdg_req_t pend_req [$];
	spdg_rsp_t path_due [$];
	spdg_rsp_t due_rsp;

	// Predictor state: the edge matrix as the block should hold it, and the
	// vertex count that was last written.
	logic [COST_W-1:0] weight_mem [NV][NV];
	int vcount_model = VCOUNT_RESET;

	// Bookkeeping for the driver, the receiver and the summary.
	logic req_fire   = 1'b0;
	int   burst_left = 1;
	int   gap_left   = 0;
	int   hold_left  = 0;
	int   cycle_count = 0;
	int   errors     = 0;
	int   n_sets     = 0;
	int   n_queries  = 0;
	int   n_results  = 0;
	int   n_settings = 0;

	always #1 clk = ~clk;

	shortest_path_dense_graph dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Path sums clamp at the all-ones weight, which also stands for "no edge".
	function automatic logic [COST_W-1:0] add_capped(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, NO_EDGE}) ? NO_EDGE : s[COST_W-1:0];
	endfunction

	// Applies one accepted request. An edge write only updates the matrix. A
	// query repeats the search the block does and queues the path edges it
	// should return, walking back from the target to the source.
	task automatic model_request(input spdg_req_t r);
		logic [COST_W-1:0] dist_v [NV];
		logic [VIDX_W-1:0] pred [NV];
		logic [VIDX_W-1:0] hop_from [MAX_RESULTS];
		logic [VIDX_W-1:0] hop_to [MAX_RESULTS];
		logic [NV-1:0]     pvalid;
		logic [NV-1:0]     open_set;
		logic [NV:0]       span;
		logic [COST_W-1:0] best;
		logic [COST_W-1:0] sum;
		logic [COST_W-1:0] total;
		logic [VIDX_W-1:0] cur;
		logic [VIDX_W-1:0] prv;
		int                u;
		int                i;
		int                cnt;
		bit                have;
		bit                ok;
		spdg_rsp_t         rsp;

		if (r.op == OP_SET_EDGE) begin
			weight_mem[r.src_vertex][r.dst_vertex] = r.edge_weight;
			n_sets++;
			return;
		end
		n_queries++;

		for (i = 0; i < NV; i++) begin
			dist_v[i] = NO_EDGE;
			pred[i] = '0;
		end
		pvalid = '0;
		span = ({{NV{1'b0}}, 1'b1} << vcount_model) - 1'b1;
		open_set = span[NV-1:0];
		dist_v[r.src_vertex] = '0;

		// Take the closest open vertex, lowest index on a tie. When nothing open
		// has a known distance, the lowest open index is taken all the same.
		while (open_set != '0) begin
			best = NO_EDGE;
			have = 1'b0;
			u = 0;
			for (i = 0; i < vcount_model; i++) begin
				if (open_set[i] && dist_v[i] < best) begin
					best = dist_v[i];
					u = i;
					have = 1'b1;
				end
			end
			if (!have) begin
				for (i = vcount_model - 1; i >= 0; i--)
					if (open_set[i])
						u = i;
			end
			open_set[u] = 1'b0;
			// Relax the whole row, visited vertices included.
			for (i = 0; i < vcount_model; i++) begin
				if (weight_mem[u][i] != NO_EDGE) begin
					sum = add_capped(dist_v[u], weight_mem[u][i]);
					if (dist_v[i] > sum) begin
						dist_v[i] = sum;
						pred[i] = u[VIDX_W-1:0];
						pvalid[i] = 1'b1;
					end
				end
			end
		end

		// Walk the predecessor chain back to the source, adding up the cost.
		ok = 1'b0;
		cnt = 0;
		total = '0;
		cur = r.dst_vertex;
		if (pvalid[cur]) begin
			while (cnt < MAX_RESULTS) begin
				prv = pred[cur];
				hop_from[cnt] = prv;
				hop_to[cnt] = cur;
				total = add_capped(total, weight_mem[prv][cur]);
				cnt++;
				if (prv == r.src_vertex) begin
					ok = 1'b1;
					break;
				end
				if (!pvalid[prv])
					break;
				cur = prv;
			end
		end

		if (!ok) begin
			rsp.edge_from = r.src_vertex;
			rsp.edge_to   = r.dst_vertex;
			rsp.path_cost = NO_EDGE;
			rsp.found     = 1'b0;
			rsp.last      = 1'b1;
			path_due = {path_due, rsp};
		end else begin
			for (i = 0; i < cnt; i++) begin
				rsp.edge_from = hop_from[i];
				rsp.edge_to   = hop_to[i];
				rsp.path_cost = total;
				rsp.found     = 1'b1;
				rsp.last      = (i == cnt - 1);
				path_due = {path_due, rsp};
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: one request at a time from the pending queue, in bursts of
	// random length with random gaps. The payload holds until it is taken.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pend_req.size() != 0) begin
				in_data  <= pend_req.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// A quarter of the bursts run straight into the next one.
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: holds out_ready at one level for a run, then picks again.
	// Long ready runs give stretches with no stalls at all.
	always @(negedge clk) begin
		if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					out_ready <= 1'b1;
					hold_left <= $urandom_range(20, 60);
				end
				1: begin
					out_ready <= 1'b0;
					hold_left <= $urandom_range(1, 8);
				end
				default: begin
					out_ready <= 1'($urandom_range(0, 1));
					hold_left <= $urandom_range(1, 3);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: takes accepted requests into the predictor and checks every
	// accepted path edge against the oldest one owed. All sampling is done at
	// the rising edge, after the bench last changed its inputs on a falling edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		req_fire <= in_valid && in_ready;
		if (cycle_count >= RUN_LIMIT) begin
			$display("%0t: run stopped after %0d cycles, %0d path edges still owed",
				$time, cycle_count, path_due.size());
			$display("shortest_path_dense_graph: mismatch");
			$finish;
		end else begin
			if (arst_n)
				cycle_count++;
			if (in_valid && in_ready)
				model_request(in_data);
			if (out_valid && out_ready) begin
				if (path_due.size() == 0) begin
					errors++;
					$display({"%0t: expected nothing, ",
						"got from=%0d to=%0d cost=%h found=%b last=%b"},
						$time, out_data.edge_from, out_data.edge_to, out_data.path_cost,
						out_data.found, out_data.last);
				end else begin
					due_rsp = path_due.pop_front();
					n_results++;
					if (out_data !== due_rsp) begin
						errors++;
						$display({"%0t: expected from=%0d to=%0d cost=%h found=%b last=%b, ",
							"got from=%0d to=%0d cost=%h found=%b last=%b"}, $time,
							due_rsp.edge_from, due_rsp.edge_to, due_rsp.path_cost,
							due_rsp.found, due_rsp.last, out_data.edge_from,
							out_data.edge_to, out_data.path_cost, out_data.found,
							out_data.last);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic push_set(input int s, input int d, input logic [COST_W-1:0] w);
		spdg_req_t r;
		r.op          = OP_SET_EDGE;
		r.src_vertex  = VIDX_W'(s);
		r.dst_vertex  = VIDX_W'(d);
		r.edge_weight = w;
		pend_req = {pend_req, r};
	endtask

	// The weight field of a query is ignored by the block, so it gets noise.
	task automatic push_query(input int s, input int d);
		spdg_req_t r;
		r.op          = OP_QUERY;
		r.src_vertex  = VIDX_W'(s);
		r.dst_vertex  = VIDX_W'(d);
		r.edge_weight = $urandom();
		pend_req = {pend_req, r};
	endtask

	// Mostly a vertex in use; now and then any index, in use or not.
	function automatic int pick_vertex(input int n);
		if (n == 0 || $urandom_range(0, 5) == 0)
			return $urandom_range(0, NV - 1);
		return $urandom_range(0, n - 1);
	endfunction

	// Small weights dominate so that paths stay finite. Zero, edge removal,
	// full-range values and weights large enough to clamp a sum come up too.
	function automatic logic [COST_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return NO_EDGE;
			2:       return $urandom();
			3:       return NO_EDGE - $urandom_range(0, 16);
			4:       return 32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// Wait until every request has gone in and every owed result has come
	// back, then give the block time to finish a trailing write.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pend_req.size() != 0 || in_valid || path_due.size() != 0);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_vcount(input int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= VCOUNT_W'(v);
		@(negedge clk);
		cfg_we    <= 1'b0;
		// Values above the matrix size are clamped by the block.
		vcount_model = (v > NV) ? NV : v;
		n_settings++;
	endtask

	// One random phase: a chain through a shuffled set of the vertices in use,
	// so that long paths exist, a query along it, and then a mix of edge
	// writes and queries. The matrix carries over from phase to phase.
	task automatic load_phase(input int n);
		int order [NV];
		int len;
		int tmp;
		int j;
		int k;
		for (k = 0; k < NV; k++)
			order[k] = k;
		for (k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		if (n >= 2) begin
			len = ($urandom_range(0, 2) == 0) ? n - 1 : $urandom_range(1, n - 1);
			for (k = 0; k < len; k++)
				push_set(order[k], order[k + 1], $urandom_range(0, 20));
			push_query(order[0], order[len]);
		end
		for (k = 0; k < 20; k++) begin
			if ($urandom_range(0, 9) < 5)
				push_set(pick_vertex(n), pick_vertex(n), pick_weight());
			else
				push_query(pick_vertex(n), pick_vertex(n));
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int i;
		int j;
		int p;
		int vc;

		for (i = 0; i < NV; i++)
			for (j = 0; j < NV; j++)
				weight_mem[i][j] = NO_EDGE;

		// Reset is held low from the start and released on a falling edge. The block
		// then clears its matrix on its own, holding off requests meanwhile.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed phase, all sixteen vertices in use.
		write_vcount(16);
		push_query(0, 5);                   // empty graph: nothing reachable
		push_query(3, 3);                   // source equal to target
		push_set(0, 1, '0);                 // zero-weight edge
		push_set(1, 2, NO_EDGE - 1);        // largest weight that is still an edge
		push_set(2, 3, 5);                  // this sum clamps and never improves
		push_query(0, 2);                   // path 0->1->2, cost just below all ones
		push_query(0, 3);                   // blocked by the clamped sum
		push_set(0, 4, 3);
		push_set(0, 5, 1);
		push_set(5, 4, 2);                  // equal cost, first predecessor stays
		push_query(0, 4);
		push_set(1, 2, NO_EDGE);            // removes the edge again
		push_query(0, 2);
		push_set(15, 0, 7);
		push_query(15, 1);                  // top index as source
		wait_idle();

		// Random phases. Besides the extremes of the range, the register also
		// sees zero vertices in use and a value past the matrix size.
		for (p = 0; p < 12; p++) begin
			case (p)
				0:       vc = 1;
				1:       vc = 31;
				2:       vc = 0;
				3:       vc = 2;
				4, 11:   vc = 16;
				default: vc = $urandom_range(1, 16);
			endcase
			write_vcount(vc);
			load_phase(vcount_model);
			wait_idle();
		end

		// Let anything stray come out before the verdict.
		repeat (END_WAIT) @(posedge clk);

		$display("covered %0d requests: %0d edge writes and %0d path queries",
			n_sets + n_queries, n_sets, n_queries);
		$display("checked %0d path edges over %0d vertex-count settings, %0d errors",
			n_results, n_settings, errors);
		if (errors == 0 && path_due.size() == 0)
			$display("shortest_path_dense_graph: match");
		else
			$display("shortest_path_dense_graph: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/spdg_pkg.sv
rtl/spdg_ram.sv
rtl/shortest_path_dense_graph.sv
rtl/spdg_checker.sv
dv/tb.sv
